>>> hw/rtl/qhsv_pkg.sv
package qhsv_pkg;

    // Fixed widths of the request and result fields.
    localparam int QIDX_W = 4;
    localparam int PROB_W = 17;

    // Probability of 1.0 in Q16.
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

    // Operation codes carried by the kind field.
    localparam logic KIND_GATE    = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } core_state_t;

endpackage

>>> hw/rtl/qubit_hadamard_state_vector_core.sv
// Channel   Signals                                 Direction  Moves
// input     in_valid, in_ready, kind, target_qubit  in         one gate or measure request
// output    out_valid, out_ready, zero_probability  out        one probability (measure only)
//
// Every measure, and every gate on a qubit below QUBITS, sweeps all 2^QUBITS amplitudes
// through the single read port of the amplitude memory, one entry per cycle. The next
// request is accepted only after the sweep and the drain have finished; a measure also
// loads the output register before then. A gate on a qubit at or beyond QUBITS is a no-op
// and leaves the block idle and ready. After reset a clearing pass loads 1.0 at index zero
// and zero elsewhere; in_ready stays low during that pass. A stalled result
// waits in the output register while the next request is accepted and processed; a
// measure that finishes while the previous result is still pending holds there.
module qubit_hadamard_state_vector_core #(
    parameter int QUBITS        = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [qhsv_pkg::QIDX_W-1:0]   target_qubit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qhsv_pkg::PROB_W-1:0]   zero_probability
);

    import qhsv_pkg::*;

    // Amplitudes are signed Q(FRACTION_BITS) with two integer bits.
    localparam int AMP_COUNT = 1 << QUBITS;
    localparam int AW        = FRACTION_BITS + 2;
    localparam int SW        = AW + 1;
    localparam int KW        = FRACTION_BITS + 1;
    localparam int PW        = SW + KW;
    localparam int QW        = 2 * AW;
    localparam int ACCW      = 2 * FRACTION_BITS + 1;

    // 0.707 in Q(FRACTION_BITS), rounded to nearest.
    localparam logic signed [KW-1:0] GATE_K =
        KW'(((64'd707 << FRACTION_BITS) + 64'd500) / 64'd1000);
    localparam logic [AW-1:0] AMP_ONE = AW'(64'd1 << FRACTION_BITS);
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'd1 << (FRACTION_BITS + 1)) - 64'd1);
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [QW-1:0] ONE_SQ = QW'(64'd1 << (2 * FRACTION_BITS));

    // Control state.
    core_state_t state_reg, state_next;
    logic [QUBITS-1:0] cnt_reg;
    logic [1:0]        dcnt_reg;
    logic              out_valid_reg;

    // Request captured at acceptance.
    logic                 kind_reg;
    logic [QIDX_W-1:0]    q_reg;

    // FSM outputs.
    logic accept;
    logic issue;
    logic clr_we;
    logic load_out;
    logic gate_noop;

    // Amplitude memory.
    logic [AW-1:0]        amp_mem [AMP_COUNT];
    logic signed [AW-1:0] rd_data_reg;
    logic [QUBITS-1:0]    rd_addr;
    logic                 mem_we;
    logic [QUBITS-1:0]    mem_waddr;
    logic [AW-1:0]        mem_wdata;

    // Address generation.
    logic [QUBITS-1:0] low_mask;
    logic [QUBITS-1:0] bit_mask;
    logic [QUBITS-1:0] pair_idx;
    logic [QUBITS-1:0] addr_a;
    logic [QUBITS-1:0] shr_idx;

    // Pipeline after the memory read.
    logic                 d_valid_reg;
    logic                 d_phase_reg;
    logic [QUBITS-1:0]    d_addr_a_reg;
    logic                 d_incl_reg;
    logic signed [AW-1:0] a_hold_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] diff_reg;
    logic [QUBITS-1:0]    s_addr_reg;
    logic                 s_valid_reg;
    logic                 s2_reg;
    logic signed [SW-1:0] mul_op;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic                 w_valid_reg;
    logic [QUBITS-1:0]    w_addr_reg;
    logic signed [PW-1:0] shifted;
    logic [AW-1:0]        sat_amp;

    // Measure datapath.
    logic signed [QW-1:0] sq_full;
    logic [QW-2:0]        sq_reg;
    logic                 sq_v_reg;
    logic [ACCW-1:0]      acc_reg;
    logic [QW-1:0]        acc_sum;
    logic [ACCW-1:0]      acc_next;
    logic [PROB_W-1:0]    prob_reg;

    assign accept    = in_valid && in_ready;
    assign gate_noop = (kind == KIND_GATE) && (32'(target_qubit) >= QUBITS);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&cnt_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && !gate_noop)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (&cnt_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (&dcnt_reg)
                    state_next = (kind_reg == KIND_MEASURE) ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        clr_we   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_CLEAR:  clr_we   = 1'b1;
            ST_IDLE:   in_ready = 1'b1;
            ST_RUN:    issue    = 1'b1;
            ST_DRAIN:  issue    = 1'b0;
            ST_RESULT: load_out = !out_valid_reg || out_ready;
            default:   issue    = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            d_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            s2_reg        <= 1'b0;
            w_valid_reg   <= 1'b0;
            sq_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_we || issue)
                cnt_reg <= cnt_reg + QUBITS'(1);
            if (state_reg == ST_DRAIN)
                dcnt_reg <= dcnt_reg + 2'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            d_valid_reg <= issue;
            s_valid_reg <= d_valid_reg && (kind_reg == KIND_GATE) && d_phase_reg;
            s2_reg      <= s_valid_reg;
            w_valid_reg <= s_valid_reg || s2_reg;
            sq_v_reg    <= d_valid_reg && (kind_reg == KIND_MEASURE) && d_incl_reg;
        end
    end

    // Pair addresses: the pair number with a zero inserted at the target bit.
    always_comb
    begin
        low_mask = (QUBITS'(1) << q_reg) - QUBITS'(1);
        bit_mask = QUBITS'(1) << q_reg;
        pair_idx = cnt_reg >> 1;
        addr_a   = ((pair_idx & ~low_mask) << 1) | (pair_idx & low_mask);
        shr_idx  = cnt_reg >> q_reg;
        if (kind_reg == KIND_GATE)
            rd_addr = cnt_reg[0] ? (addr_a | bit_mask) : addr_a;
        else
            rd_addr = cnt_reg;
    end

    // The second product of a pair goes to the partner entry.
    always_comb
    begin
        mul_op    = s_valid_reg ? sum_reg : diff_reg;
        prod_next = mul_op * GATE_K;
        shifted   = prod_reg >>> FRACTION_BITS;
        if (shifted > SAT_HI)
            sat_amp = AW'(SAT_HI);
        else if (shifted < SAT_LO)
            sat_amp = AW'(SAT_LO);
        else
            sat_amp = AW'(shifted);
    end

    always_comb
    begin
        mem_we    = clr_we || w_valid_reg;
        mem_waddr = clr_we ? cnt_reg : w_addr_reg;
        if (clr_we)
            mem_wdata = (cnt_reg == '0) ? AMP_ONE : '0;
        else
            mem_wdata = sat_amp;
    end

    // Squares are never negative, and the running sum saturates at 1.0.
    always_comb
    begin
        sq_full = rd_data_reg * rd_data_reg;
        acc_sum = QW'(acc_reg) + QW'(sq_reg);
        if (acc_sum > ONE_SQ)
            acc_next = ACCW'(ONE_SQ);
        else
            acc_next = ACCW'(acc_sum);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            amp_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= amp_mem[rd_addr];
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            q_reg    <= target_qubit;
        end
        d_phase_reg  <= cnt_reg[0];
        d_addr_a_reg <= addr_a;
        d_incl_reg   <= !shr_idx[0];
        if (d_valid_reg && !d_phase_reg)
            a_hold_reg <= rd_data_reg;
        if (d_valid_reg && d_phase_reg)
        begin
            sum_reg    <= SW'(a_hold_reg) + SW'(rd_data_reg);
            diff_reg   <= SW'(a_hold_reg) - SW'(rd_data_reg);
            s_addr_reg <= d_addr_a_reg;
        end
        prod_reg   <= prod_next;
        w_addr_reg <= s_valid_reg ? s_addr_reg : (s_addr_reg | bit_mask);
        sq_reg     <= sq_full[QW-2:0];
        if (accept)
            acc_reg <= '0;
        else if (sq_v_reg)
            acc_reg <= acc_next;
        if (load_out)
            prob_reg <= acc_reg[ACCW-1 -: PROB_W];
    end

    assign out_valid        = out_valid_reg;
    assign zero_probability = prob_reg;

endmodule

>>> hw/rtl/qhsv_checker.sv
module qhsv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          kind,
    input logic [qhsv_pkg::QIDX_W-1:0]   target_qubit,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [qhsv_pkg::PROB_W-1:0]   zero_probability
);

    import qhsv_pkg::*;

    // A result waiting on a stalled output keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(zero_probability))
    else $error("stalled result changed or dropped");

    // A probability never exceeds 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zero_probability <= PROB_ONE)
    else $error("probability above 1.0");

    // A measure sweeps the memory, so the block is busy right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_MEASURE |=> !in_ready)
    else $error("measure accepted without a sweep");

    // A gate gives no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_GATE && !out_valid |=> !out_valid)
    else $error("gate produced a result");

endmodule

bind qubit_hadamard_state_vector_core qhsv_checker u_qhsv_checker (.*);
